/* hdl/kmcpig_pkg.sv */
// Shared types and constants for the point-island growth step core.
// Used by kmcpig_ctrl, kmcpig_dpath and the top level; no dependencies.
package kmcpig_pkg;

   localparam int SIDE_DEF   = 256;
   localparam int CHOICE_W   = 14;
   localparam int COORD_W    = 8;
   localparam int PICK_W     = 31;
   localparam int DIR_W      = 2;
   localparam int DEPW_W     = 20;
   localparam int DIFW_W     = 24;
   localparam int MONO_OUT_W = 17;
   localparam int CNT_W      = 16;
   localparam int HEIGHT_W   = 8;
   localparam int REQ_W      = 64;
   localparam int RSP_W      = 72;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_W      = 24;
   localparam int DEPX_W     = DEPW_W + CHOICE_W;

   localparam logic [CSR_IDX_W-1:0] CSR_DEP_WEIGHT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIF_WEIGHT = 1'b1;

   localparam logic [DEPW_W-1:0]   DEP_WEIGHT_RST = 20'd90000;
   localparam logic [DIFW_W-1:0]   DIF_WEIGHT_RST = 24'd10000000;
   localparam logic [CHOICE_W-1:0] CHOICE_SCALE   = 14'd10000;
   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX     = 8'hFF;
   localparam logic [CNT_W-1:0]    CNT_MAX        = 16'hFFFF;

   typedef enum logic [DIR_W-1:0] {
      DIR_ROW_UP = 2'd0,
      DIR_COL_DN = 2'd1,
      DIR_ROW_DN = 2'd2,
      DIR_COL_UP = 2'd3
   } dir_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_CMP, ST_DECIDE, ST_REDUCE,
      ST_DEP_RD, ST_DEP_UPD, ST_DIF_WAIT, ST_DIF_RD_SRC, ST_DIF_DST, ST_DIF_RD_DST,
      ST_DIF_UPD_DST, ST_DIF_UPD_SRC, ST_RM_RD, ST_RM_WR, ST_OUT
   } ctrl_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_CLEAR, OP_LOAD, OP_MUL1, OP_MUL2, OP_MUL3, OP_CMP, OP_REDUCE,
      OP_DEP_RD, OP_DEP_UPD, OP_DIF_RD_SRC, OP_DIF_DST, OP_DIF_RD_DST,
      OP_DIF_UPD_DST, OP_DIF_UPD_SRC, OP_RM_RD, OP_RM_WR, OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      rm_src;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic red_done;
      logic is_dep;
      logic div_done;
      logic mono_zero;
      logic h_mono;
      logic dst_mono;
      logic out_busy;
   } dp_status_type;

endpackage

/* hdl/kmcpig_ctrl.sv */
// Step sequencer: clearing pass, rate compare, deposit/hop and list update order.
// Depends on kmcpig_pkg; drives kmcpig_dpath through dp_cmd_type.
module kmcpig_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  kmcpig_pkg::dp_status_type st,
   output kmcpig_pkg::dp_cmd_type    cmd
);
   import kmcpig_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rm_src_ff, rm_src_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         rm_src_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rm_src_ff <= rm_src_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      rm_src_in  = rm_src_ff;
      req_tready = 1'b0;
      cmd.op     = OP_NONE;
      cmd.rm_src = rm_src_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (st.clr_done) state_in = ST_IDLE;
            else cmd.op = OP_CLEAR;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin cmd.op = OP_MUL1; state_in = ST_MUL2; end
         ST_MUL2: begin cmd.op = OP_MUL2; state_in = ST_MUL3; end
         ST_MUL3: begin cmd.op = OP_MUL3; state_in = ST_CMP; end
         ST_CMP:  begin cmd.op = OP_CMP;  state_in = ST_DECIDE; end
         ST_DECIDE: begin
            priority if (st.is_dep) state_in = ST_REDUCE;
            else if (st.mono_zero)  state_in = ST_OUT;
            else                    state_in = ST_DIF_WAIT;
         end
         ST_REDUCE: begin
            cmd.op = OP_REDUCE;
            if (st.red_done) state_in = ST_DEP_RD;
         end
         ST_DEP_RD: begin cmd.op = OP_DEP_RD; state_in = ST_DEP_UPD; end
         ST_DEP_UPD: begin
            cmd.op = OP_DEP_UPD;
            if (st.h_mono) begin
               rm_src_in = 1'b0;
               state_in  = ST_RM_RD;
            end else begin
               state_in  = ST_OUT;
            end
         end
         ST_DIF_WAIT: begin
            if (st.div_done) state_in = ST_DIF_RD_SRC;
         end
         ST_DIF_RD_SRC:  begin cmd.op = OP_DIF_RD_SRC;  state_in = ST_DIF_DST; end
         ST_DIF_DST:     begin cmd.op = OP_DIF_DST;     state_in = ST_DIF_RD_DST; end
         ST_DIF_RD_DST:  begin cmd.op = OP_DIF_RD_DST;  state_in = ST_DIF_UPD_DST; end
         ST_DIF_UPD_DST: begin cmd.op = OP_DIF_UPD_DST; state_in = ST_DIF_UPD_SRC; end
         ST_DIF_UPD_SRC: begin
            cmd.op    = OP_DIF_UPD_SRC;
            rm_src_in = !st.dst_mono;
            state_in  = ST_RM_RD;
         end
         ST_RM_RD: begin cmd.op = OP_RM_RD; state_in = ST_RM_WR; end
         ST_RM_WR: begin
            cmd.op = OP_RM_WR;
            if (!rm_src_ff && !st.is_dep) begin
               rm_src_in = 1'b1;
               state_in  = ST_RM_RD;
            end else begin
               state_in  = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!st.out_busy) begin
               cmd.op   = OP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

/* hdl/kmcpig_dpath.sv */
// Datapath: weights, rate compare multipliers, remainder divider, height and
// monomer list memories, counters and result register. Depends on kmcpig_pkg.
module kmcpig_dpath #(
   parameter int SIDE = kmcpig_pkg::SIDE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [kmcpig_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kmcpig_pkg::CSR_W-1:0]      csr_wdata,
   input  logic [kmcpig_pkg::REQ_W-1:0]      req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [kmcpig_pkg::RSP_W-1:0]      rsp_tdata,
   output logic                              rsp_tuser,
   input  kmcpig_pkg::dp_cmd_type            cmd,
   output kmcpig_pkg::dp_status_type         st
);
   import kmcpig_pkg::*;

   localparam int CW    = $clog2(SIDE);
   localparam int AW    = 2 * CW;
   localparam int AREA  = SIDE * SIDE;
   localparam int MW    = $clog2(AREA + 1);
   localparam int SW    = $clog2(AREA);
   localparam int PW    = MW + DIFW_W;
   localparam int TW    = PW + 1;
   localparam int HW    = (TW + 1) / 2;
   localparam int UW    = TW - HW;
   localparam int LW    = CHOICE_W + TW;
   localparam int DCW   = $clog2(PICK_W + 1);
   localparam logic [CW-1:0] SIDE_TOP = CW'(SIDE - 1);
   localparam logic [MW-1:0] AREA_M   = MW'(AREA);

   // configuration
   logic [DEPW_W-1:0] dep_w_ff;
   logic [DIFW_W-1:0] dif_w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dep_w_ff <= DEP_WEIGHT_RST;
         dif_w_ff <= DIF_WEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEP_WEIGHT: dep_w_ff <= csr_wdata[DEPW_W-1:0];
            CSR_DIF_WEIGHT: dif_w_ff <= csr_wdata[DIFW_W-1:0];
            default: ;
         endcase
      end
   end

   // item capture and rate compare
   logic [CHOICE_W-1:0]  choice_ff;
   logic [COORD_W-1:0]   cx_ff, cy_ff, cx_in, cy_in;
   logic [DIR_W-1:0]     dir_ff;
   logic [PW-1:0]        prod_ff;
   logic [DEPX_W-1:0]    depx_ff;
   logic [TW-1:0]        total_ff;
   logic [CHOICE_W+HW-1:0] plo_ff;
   logic [CHOICE_W+UW-1:0] phi_ff;
   logic [LW-1:0]        lhs;
   logic                 is_dep_ff;

   // divider
   logic [MW-1:0]        div_rem_ff, div_rem_in;
   logic [MW:0]          div_trial;
   logic [PICK_W-1:0]    div_sh_ff, div_sh_in;
   logic [DCW-1:0]       div_cnt_ff, div_cnt_in;

   // lattice state
   logic [HEIGHT_W-1:0]  h_mem [2**AW];
   logic [AW-1:0]        ms_mem [2**SW];
   logic [SW-1:0]        sl_mem [2**AW];
   logic [HEIGHT_W-1:0]  h_rd_ff, h_wd;
   logic [AW-1:0]        ms_rd_ff, ms_wd, h_wa, h_ra, sl_wa, sl_ra;
   logic [SW-1:0]        sl_rd_ff, sl_wd, ms_wa, ms_ra;
   logic                 h_we, ms_we, sl_we;

   logic [AW-1:0]        src_ff, src_in, dst_ff, dst_in, tgt;
   logic [CW-1:0]        r_s, c_s, r_n, c_n;
   logic                 dst_mono_ff, dst_mono_in;
   logic [AW:0]          clr_ff, clr_in;
   logic [MW-1:0]        mt_ff, mt_in, mt_dec;
   logic [CNT_W-1:0]     isl_ff, isl_in, dep_ff, dep_in;
   logic                 do_add;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]     rsp_data_ff;
   logic                 rsp_user_ff;

   assign mt_dec = mt_ff - MW'(1);
   assign tgt    = cmd.rm_src ? src_ff : dst_ff;
   assign lhs    = {phi_ff, {HW{1'b0}}} + LW'(plo_ff);
   assign div_trial = {div_rem_ff, div_sh_ff[PICK_W-1]};

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            choice_ff <= req_tdata[CHOICE_W-1:0];
            dir_ff    <= req_tdata[62:61];
         end
         OP_MUL1: begin
            prod_ff <= mt_ff * dif_w_ff;
            depx_ff <= dep_w_ff * CHOICE_SCALE;
         end
         OP_MUL2: total_ff <= TW'(prod_ff) + TW'(dep_w_ff);
         OP_MUL3: begin
            plo_ff <= choice_ff * total_ff[HW-1:0];
            phi_ff <= choice_ff * total_ff[TW-1:HW];
         end
         OP_CMP:  is_dep_ff <= lhs < LW'(depx_ff);
         default: ;
      endcase
      cx_ff <= cx_in;
      cy_ff <= cy_in;
   end

   always_comb begin
      cx_in = cx_ff;
      cy_in = cy_ff;
      if (cmd.op == OP_LOAD) begin
         cx_in = req_tdata[21:14];
         cy_in = req_tdata[29:22];
      end else if (cmd.op == OP_REDUCE) begin
         if (int'(cx_ff) >= SIDE) cx_in = cx_ff - COORD_W'(SIDE);
         if (int'(cy_ff) >= SIDE) cy_in = cy_ff - COORD_W'(SIDE);
      end
   end

   // remainder pick_draw mod monomer count, one bit per cycle
   always_comb begin
      div_rem_in = div_rem_ff;
      div_sh_in  = div_sh_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.op == OP_LOAD) begin
         div_rem_in = '0;
         div_sh_in  = req_tdata[60:30];
         div_cnt_in = DCW'(PICK_W);
      end else if (div_cnt_ff != '0) begin
         div_rem_in = (div_trial >= {1'b0, mt_ff}) ? MW'(div_trial - {1'b0, mt_ff})
                                                   : MW'(div_trial);
         div_sh_in  = {div_sh_ff[PICK_W-2:0], 1'b0};
         div_cnt_in = div_cnt_ff - DCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      div_rem_ff <= div_rem_in;
      div_sh_ff  <= div_sh_in;
      if (reset) div_cnt_ff <= '0;
      else       div_cnt_ff <= div_cnt_in;
   end

   // hop destination from the picked site
   always_comb begin
      r_s = ms_rd_ff[AW-1:CW];
      c_s = ms_rd_ff[CW-1:0];
      r_n = r_s;
      c_n = c_s;
      unique case (dir_type'(dir_ff))
         DIR_ROW_UP: r_n = (r_s == SIDE_TOP) ? '0 : r_s + CW'(1);
         DIR_COL_DN: c_n = (c_s == '0) ? SIDE_TOP : c_s - CW'(1);
         DIR_ROW_DN: r_n = (r_s == '0) ? SIDE_TOP : r_s - CW'(1);
         DIR_COL_UP: c_n = (c_s == SIDE_TOP) ? '0 : c_s + CW'(1);
         default: ;
      endcase
   end

   always_comb begin
      h_we   = 1'b0;
      h_wa   = dst_ff;
      h_wd   = h_rd_ff + HEIGHT_W'(1);
      h_ra   = dst_ff;
      ms_we  = 1'b0;
      ms_wa  = mt_ff[SW-1:0];
      ms_wd  = dst_ff;
      ms_ra  = mt_dec[SW-1:0];
      sl_we  = 1'b0;
      sl_wa  = dst_ff;
      sl_wd  = mt_ff[SW-1:0];
      sl_ra  = tgt;
      src_in = src_ff;
      dst_in = dst_ff;
      dst_mono_in = dst_mono_ff;
      clr_in = clr_ff;
      mt_in  = mt_ff;
      isl_in = isl_ff;
      dep_in = dep_ff;
      do_add = 1'b0;
      unique case (cmd.op)
         OP_CLEAR: begin
            h_we   = 1'b1;
            h_wa   = clr_ff[AW-1:0];
            h_wd   = '0;
            clr_in = clr_ff + (AW+1)'(1);
         end
         OP_LOAD: dst_in = '0;
         OP_DEP_RD: begin
            dst_in = {CW'(cx_ff), CW'(cy_ff)};
            h_ra   = {CW'(cx_ff), CW'(cy_ff)};
         end
         OP_DEP_UPD: begin
            h_we   = h_rd_ff != HEIGHT_MAX;
            do_add = h_rd_ff == '0;
            if (h_rd_ff == HEIGHT_W'(1) && isl_ff != CNT_MAX) isl_in = isl_ff + CNT_W'(1);
            if (dep_ff != CNT_MAX) dep_in = dep_ff + CNT_W'(1);
         end
         OP_DIF_RD_SRC: ms_ra = div_rem_ff[SW-1:0];
         OP_DIF_DST: begin
            src_in = ms_rd_ff;
            dst_in = {r_n, c_n};
         end
         OP_DIF_RD_DST: h_ra = dst_ff;
         OP_DIF_UPD_DST: begin
            h_we   = h_rd_ff != HEIGHT_MAX;
            do_add = h_rd_ff == '0;
            dst_mono_in = h_rd_ff == HEIGHT_W'(1);
            if (h_rd_ff == HEIGHT_W'(1) && isl_ff != CNT_MAX) isl_in = isl_ff + CNT_W'(1);
            h_ra   = src_ff;
         end
         OP_DIF_UPD_SRC: begin
            h_we = h_rd_ff != '0;
            h_wa = src_ff;
            h_wd = h_rd_ff - HEIGHT_W'(1);
         end
         OP_RM_WR: begin
            if (mt_ff != '0) begin
               ms_we = 1'b1;
               ms_wa = sl_rd_ff;
               ms_wd = ms_rd_ff;
               sl_we = 1'b1;
               sl_wa = ms_rd_ff;
               sl_wd = sl_rd_ff;
               mt_in = mt_dec;
            end
         end
         default: ;
      endcase
      if (do_add && mt_ff < AREA_M) begin
         ms_we = 1'b1;
         sl_we = 1'b1;
         mt_in = mt_ff + MW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (h_we) h_mem[h_wa] <= h_wd;
      h_rd_ff <= h_mem[h_ra];
   end

   always_ff @(posedge clock) begin
      if (ms_we) ms_mem[ms_wa] <= ms_wd;
      ms_rd_ff <= ms_mem[ms_ra];
   end

   always_ff @(posedge clock) begin
      if (sl_we) sl_mem[sl_wa] <= sl_wd;
      sl_rd_ff <= sl_mem[sl_ra];
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      dst_mono_ff <= dst_mono_in;
      if (reset) begin
         clr_ff <= '0;
         mt_ff  <= '0;
         isl_ff <= '0;
         dep_ff <= '0;
      end else begin
         clr_ff <= clr_in;
         mt_ff  <= mt_in;
         isl_ff <= isl_in;
         dep_ff <= dep_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.op == OP_OUT) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
      if (cmd.op == OP_OUT) begin
         rsp_user_ff <= !is_dep_ff;
         rsp_data_ff <= {7'd0, dep_ff, isl_ff, MONO_OUT_W'(mt_ff),
                         COORD_W'(dst_ff[CW-1:0]), COORD_W'(dst_ff[AW-1:CW])};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign st.clr_done  = clr_ff[AW];
   assign st.red_done  = (int'(cx_ff) < SIDE) && (int'(cy_ff) < SIDE);
   assign st.is_dep    = is_dep_ff;
   assign st.div_done  = div_cnt_ff == '0;
   assign st.mono_zero = mt_ff == '0;
   assign st.h_mono    = h_rd_ff == HEIGHT_W'(1);
   assign st.dst_mono  = dst_mono_ff;
   assign st.out_busy  = rsp_valid_ff && !rsp_tready;

endmodule

/* hdl/kmc_point_island_growth_step_core.sv */
// Point-island growth KMC step core: one deposition or monomer hop per item; with no
// monomers a hop item makes no move. A deposition first reduces any coordinate at or above
// SIDE by SIDE, then one that lands on a monomer nucleates an island and drops it from the list;
// a hop waits for the pick remainder, then does list updates, dropping both monomers on a merge.
// Throughput: one item at a time; the result waits while an untaken one is still held.
// Reset: synchronous; then a clearing pass that zeroes every height memory entry.
module kmc_point_island_growth_step_core #(
   parameter int SIDE = kmcpig_pkg::SIDE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [kmcpig_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [kmcpig_pkg::CSR_W-1:0]     csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // choice_draw[13:0], deposit_x[21:14], deposit_y[29:22], pick_draw[60:30], hop_dir[62:61]
   input  logic [kmcpig_pkg::REQ_W-1:0]     req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // site_x[7:0], site_y[15:8], monomers_now[32:16], islands_now[48:33], deposits_now[64:49]
   output logic [kmcpig_pkg::RSP_W-1:0]     rsp_tdata,
   // event_kind[0]
   output logic                             rsp_tuser
);
   import kmcpig_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type st;

   kmcpig_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   kmcpig_dpath #(.SIDE(SIDE)) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .st         (st)
   );

`ifndef NO_ASSERTIONS
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while a step is in progress");

   a_result_then_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result loaded but sequencer not idle");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("activity right after reset");
`endif

endmodule
